// ===== design/r250_pkg.sv =====
`default_nettype none
package r250_pkg;
	localparam int WORD_W = 16;
	localparam int LAG = 103;
	localparam logic [31:0] LCG_MULT = 32'h015a4e35;
	localparam logic [1:0] OP_RAW = 2'd0;
	localparam logic [1:0] OP_RANGED = 2'd1;
	localparam logic [1:0] OP_RESEED = 2'd2;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ZERO_LIMIT = 1'b1;

	typedef struct packed {
		logic shift;
		logic load;
		logic [WORD_W-1:0] load_word;
	} cell_ctl_t;

	// One congruential step.
	function automatic logic [31:0] lcg_step(input logic [31:0] x);
		lcg_step = x * LCG_MULT + 32'd1;
	endfunction
endpackage
`default_nettype wire

// ===== design/r250_if.sv =====
`default_nettype none
interface r250_req_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [15:0] range_limit;
	modport source (output valid, output operation, output range_limit, input ready);
	modport sink (input valid, input operation, input range_limit, output ready);
endinterface

interface r250_rsp_if;
	logic valid;
	logic ready;
	logic [15:0] draw_value;
	logic status;
	modport source (output valid, output draw_value, output status, input ready);
	modport sink (input valid, input draw_value, input status, output ready);
endinterface
`default_nettype wire

// ===== design/r250_cell.sv =====
`default_nettype none
// One word of the rotating store; each shift moves the word one place on.
module r250_cell (
	input wire logic clk,
	input wire r250_pkg::cell_ctl_t ctl,
	input wire logic [r250_pkg::WORD_W-1:0] prev_word,
	output logic [r250_pkg::WORD_W-1:0] word_q
);
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			word_q <= ctl.load ? ctl.load_word : prev_word;
		end
	end
endmodule
`default_nettype wire

// ===== design/r250_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module r250_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [15:0] dividend,
	input wire logic [15:0] divisor,
	output logic busy_q,
	output logic [15:0] quot_q,
	output logic [15:0] rem_q
);
	logic [4:0] cnt_q;
	logic [16:0] trial;
	assign trial = {rem_q, quot_q[15]} - {1'b0, divisor};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd16;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) busy_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quot_q <= {quot_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quot_q[15]};
				quot_q <= {quot_q[14:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/r250_random_generator_core.sv =====
`default_nettype none
// Lagged-Fibonacci (250, 103) XOR generator of 16-bit numbers. The 250 words sit
// in a ring of cells that rotates by one word per cycle while a pass or a draw
// shifts it; the head word and the word 103 places on are read at fixed taps.
// A raw draw goes through the S_RAW and S_OUT states to its result. A ranged draw
// works out its bound in the shared one-bit-per-cycle divider, then draws word
// pairs and takes the final remainder in the same divider before the result.
// A reseed runs a word fill pass, a top-bit pass and a pass that applies the
// diagonal fixup before its result; reset starts the same pass, during which no
// item is accepted (seed writes are always taken).
module r250_random_generator_core #(
	parameter int STORE_WORDS = 250
) (
	input wire logic clk,
	input wire logic arst_n,
	r250_req_if.sink req,
	r250_rsp_if.source rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int IW = $clog2(STORE_WORDS);
	localparam logic [IW-1:0] LAST = IW'(STORE_WORDS - 1);
	localparam logic [3:0] S_IDLE = 4'd0, S_FILL = 4'd1, S_TOP = 4'd2, S_FIX = 4'd3,
		S_RAW = 4'd4, S_DIVB = 4'd5, S_MUL = 4'd6, S_PAIR = 4'd7, S_MOD = 4'd8,
		S_OUT = 4'd9, S_DIVW = 4'd10, S_MODW = 4'd11, S_RAW2 = 4'd12;

	logic [31:0] seed_q, lcg_q;
	logic [3:0] state_q;
	logic [IW-1:0] cnt_q;
	logic [3:0] fix_q;
	logic [15:0] mask_q, msb_q, lim_q, bound_q, val_q;
	logic pair_q;
	logic rsp_valid_q;
	logic [15:0] rsp_val_q;
	logic rsp_stat_q;
	logic boot_q;
	logic [15:0] words [STORE_WORDS];
	r250_pkg::cell_ctl_t ctl [STORE_WORDS];
	logic shift;
	logic [15:0] head_new;
	logic [15:0] xr;
	logic [31:0] lcg_nx;
	logic dstart, dbusy;
	logic [15:0] dnd, dsr, dq, dr;
	logic [31:0] prod;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? seed_q : 32'd0;
	assign lcg_nx = r250_pkg::lcg_step(lcg_q);
	assign xr = words[0] ^ words[r250_pkg::LAG];
	assign prod = 32'(bound_q) * 32'(lim_q);

	// Rotation: cell i takes the word of cell i+1, the last cell takes the new head.
	always_comb begin
		shift = 1'b0;
		head_new = words[0];
		unique case (state_q)
			S_FILL: begin shift = 1'b1; head_new = {1'b0, lcg_nx[30:16]}; end
			S_TOP: begin
				shift = 1'b1;
				head_new = words[0] | ((lcg_nx[30:16] > 15'd16384) ? 16'h8000 : 16'h0);
			end
			S_FIX: begin
				shift = 1'b1;
				head_new = (cnt_q == IW'(11 * fix_q + 3)) ? ((words[0] & mask_q) | msb_q)
					: words[0];
			end
			S_RAW, S_RAW2, S_PAIR: begin shift = 1'b1; head_new = xr; end
			default: ;
		endcase
	end

	for (genvar i = 0; i < STORE_WORDS; i++) begin : g_cell
		assign ctl[i].shift = shift;
		assign ctl[i].load = (i == STORE_WORDS - 1);
		assign ctl[i].load_word = head_new;
		r250_cell u_cell (
			.clk(clk), .ctl(ctl[i]),
			.prev_word(words[(i + 1) % STORE_WORDS]), .word_q(words[i])
		);
	end

	r250_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(dnd), .divisor(dsr),
		.busy_q(dbusy), .quot_q(dq), .rem_q(dr)
	);
	assign dstart = (state_q == S_DIVB) || (state_q == S_MOD);
	assign dnd = (state_q == S_DIVB) ? 16'hffff : val_q;
	assign dsr = lim_q;

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.draw_value = rsp_val_q;
	assign rsp.status = rsp_stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd12345;
			lcg_q <= 32'd12345;
			state_q <= S_FILL;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == 2'd0) seed_q <= pwdata;
			if (rsp.valid && rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					lim_q <= req.range_limit;
					unique case (req.operation)
						r250_pkg::OP_RAW: state_q <= S_RAW;
						r250_pkg::OP_RANGED: begin
							if (req.range_limit == 16'd0) begin
								rsp_val_q <= 16'd0;
								rsp_stat_q <= r250_pkg::STATUS_ZERO_LIMIT;
								rsp_valid_q <= 1'b1;
							end else state_q <= S_DIVB;
						end
						r250_pkg::OP_RESEED: begin
							lcg_q <= seed_q;
							// The current head becomes word 0; the ring rotates back to it
							// after each pass.
							cnt_q <= '0;
							state_q <= S_FILL;
						end
						default: begin
							rsp_val_q <= 16'd0;
							rsp_stat_q <= r250_pkg::STATUS_OK;
							rsp_valid_q <= 1'b1;
						end
					endcase
				end
				S_FILL, S_TOP: begin
					lcg_q <= lcg_nx;
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						state_q <= (state_q == S_FILL) ? S_TOP : S_FIX;
						fix_q <= '0;
						mask_q <= 16'hffff;
						msb_q <= 16'h8000;
					end
				end
				S_FIX: begin
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
					if (cnt_q == IW'(11 * fix_q + 3)) begin
						fix_q <= fix_q + 4'd1;
						mask_q <= mask_q >> 1;
						msb_q <= msb_q >> 1;
					end
					if (cnt_q == LAST) begin
						state_q <= S_OUT;
						val_q <= 16'd0;
					end
				end
				S_RAW: begin
					val_q <= xr;
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
					state_q <= S_OUT;
				end
				S_DIVB: state_q <= S_DIVW;
				S_DIVW: if (!dbusy) begin bound_q <= dq; state_q <= S_MUL; end
				S_MUL: begin bound_q <= prod[15:0]; state_q <= S_PAIR; pair_q <= 1'b0; end
				S_PAIR: begin
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
					pair_q <= ~pair_q;
					if (pair_q && xr < bound_q) begin
						val_q <= xr;
						state_q <= S_MOD;
					end
				end
				S_MOD: state_q <= S_MODW;
				S_MODW: if (!dbusy) begin val_q <= dr; state_q <= S_OUT; end
				S_OUT: begin
					rsp_val_q <= val_q;
					rsp_stat_q <= r250_pkg::STATUS_OK;
					// Reset reseed delivers no result.
					rsp_valid_q <= !boot_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) boot_q <= 1'b1;
		else if (state_q == S_OUT) boot_q <= 1'b0;
	end
endmodule
`default_nettype wire
